/* src/pvl_pkg.sv */
// shared types, constants and operation codes for the pi voltage loop core
`default_nettype none

package pvl_pkg;

    // adc width actually used from the feedback sample
    localparam int ADC_BITS = 12;
    localparam int SAMPLE_W = 12;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
        (ADC_BITS >= SAMPLE_W) ? {SAMPLE_W{1'b1}} : SAMPLE_W'((1 << ADC_BITS) - 1);

    // configuration register indexes
    localparam logic [2:0] REG_SETPOINT_LEVEL = 3'd0;
    localparam logic [2:0] REG_FEEDBACK_GAIN  = 3'd1;
    localparam logic [2:0] REG_PROP_GAIN      = 3'd2;
    localparam logic [2:0] REG_INT_GAIN       = 3'd3;
    localparam logic [2:0] REG_INT_STEP       = 3'd4;
    localparam logic [2:0] REG_OUTPUT_UPPER   = 3'd5;
    localparam logic [2:0] REG_OUTPUT_LOWER   = 3'd6;
    localparam logic [2:0] REG_PERIOD_COUNT   = 3'd7;

    // register reset values
    localparam logic [16:0] SETPOINT_LEVEL_RST = 17'd39322;
    localparam logic [15:0] FEEDBACK_GAIN_RST  = 16'd64503;
    localparam logic [15:0] PROP_GAIN_RST      = 16'd256;
    localparam logic [15:0] INT_GAIN_RST       = 16'd3072;
    localparam logic [15:0] INT_STEP_RST       = 16'd33;
    localparam logic [16:0] OUTPUT_UPPER_RST   = 17'd65536;
    localparam logic [16:0] OUTPUT_LOWER_RST   = 17'd0;
    localparam logic [15:0] PERIOD_COUNT_RST   = 16'd2880;

    localparam logic signed [47:0] INTEG_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] INTEG_MIN = 48'sh8000_0000_0000;

    typedef struct packed {
        logic [16:0] setpoint_level;
        logic [15:0] feedback_gain;
        logic [15:0] prop_gain;
        logic [15:0] int_gain;
        logic [15:0] int_step;
        logic [16:0] output_upper;
        logic [16:0] output_lower;
        logic [15:0] period_count;
    } cfg_t;

    // datapath operation codes, one per sequencer step
    typedef logic [3:0] op_t;
    localparam op_t OP_NONE = 4'd0;
    localparam op_t OP_LOAD = 4'd1;
    localparam op_t OP_FB   = 4'd2;
    localparam op_t OP_ILO  = 4'd3;
    localparam op_t OP_IHI  = 4'd4;
    localparam op_t OP_P    = 4'd5;
    localparam op_t OP_STEP = 4'd6;
    localparam op_t OP_UPD  = 4'd7;
    localparam op_t OP_DUTY = 4'd8;
    localparam op_t OP_OUT  = 4'd9;

    typedef struct packed {
        op_t op;
    } dp_cmd_t;

endpackage

`default_nettype wire

/* src/pi_voltage_loop_pwm_core.sv */
// top level of the pi voltage loop with pwm duty output
// One feedback adc word per control tick goes in on the s_axis side; one result word comes
// out on the m_axis side with the pwm compare count and the clamp and hold flags. A new item
// is accepted only once the previous one has left the sequencer; a single 25x17 multiplier
// is shared by the six products of a tick (feedback scaling, two halves of the integral term,
// proportional term, integrator step and duty scaling). The finished result sits in an output
// register, so a new sample is taken while the previous result still waits. The apb registers
// must be written only while no tick is in flight; the block itself does not enforce this.
// The integrator resets to zero.
`default_nettype none

module pi_voltage_loop_pwm_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [11:0] feedback_sample, [15:12] zero
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [15:0] duty_count, [16] clamped_high,
                                             // [17] clamped_low, [18] integrator_held,
                                             // [23:19] zero
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    pvl_pkg::cfg_t    cfg;
    pvl_pkg::dp_cmd_t cmd;
    logic [15:0]      duty_count;
    logic             clamped_high;
    logic             clamped_low;
    logic             integrator_held;

    pvl_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pvl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    pvl_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .cmd             (cmd),
        .feedback_sample (s_axis_tdata[11:0]),
        .duty_count      (duty_count),
        .clamped_high    (clamped_high),
        .clamped_low     (clamped_low),
        .integrator_held (integrator_held)
    );

    assign m_axis_tdata = {5'd0, integrator_held, clamped_low, clamped_high, duty_count};

endmodule

`default_nettype wire

/* src/pvl_regs.sv */
// apb configuration register file
`default_nettype none

module pvl_regs (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output pvl_pkg::cfg_t     cfg
);

    logic [16:0] setpoint_level_reg;
    logic [15:0] feedback_gain_reg;
    logic [15:0] prop_gain_reg;
    logic [15:0] int_gain_reg;
    logic [15:0] int_step_reg;
    logic [16:0] output_upper_reg;
    logic [16:0] output_lower_reg;
    logic [15:0] period_count_reg;
    logic        wr_en;
    logic [2:0]  idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign idx    = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_level_reg <= pvl_pkg::SETPOINT_LEVEL_RST;
            feedback_gain_reg  <= pvl_pkg::FEEDBACK_GAIN_RST;
            prop_gain_reg      <= pvl_pkg::PROP_GAIN_RST;
            int_gain_reg       <= pvl_pkg::INT_GAIN_RST;
            int_step_reg       <= pvl_pkg::INT_STEP_RST;
            output_upper_reg   <= pvl_pkg::OUTPUT_UPPER_RST;
            output_lower_reg   <= pvl_pkg::OUTPUT_LOWER_RST;
            period_count_reg   <= pvl_pkg::PERIOD_COUNT_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                pvl_pkg::REG_SETPOINT_LEVEL: setpoint_level_reg <= pwdata[16:0];
                pvl_pkg::REG_FEEDBACK_GAIN:  feedback_gain_reg  <= pwdata[15:0];
                pvl_pkg::REG_PROP_GAIN:      prop_gain_reg      <= pwdata[15:0];
                pvl_pkg::REG_INT_GAIN:       int_gain_reg       <= pwdata[15:0];
                pvl_pkg::REG_INT_STEP:       int_step_reg       <= pwdata[15:0];
                pvl_pkg::REG_OUTPUT_UPPER:   output_upper_reg   <= pwdata[16:0];
                pvl_pkg::REG_OUTPUT_LOWER:   output_lower_reg   <= pwdata[16:0];
                pvl_pkg::REG_PERIOD_COUNT:   period_count_reg   <= pwdata[15:0];
                default:                     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            pvl_pkg::REG_SETPOINT_LEVEL: prdata = {15'd0, setpoint_level_reg};
            pvl_pkg::REG_FEEDBACK_GAIN:  prdata = {16'd0, feedback_gain_reg};
            pvl_pkg::REG_PROP_GAIN:      prdata = {16'd0, prop_gain_reg};
            pvl_pkg::REG_INT_GAIN:       prdata = {16'd0, int_gain_reg};
            pvl_pkg::REG_INT_STEP:       prdata = {16'd0, int_step_reg};
            pvl_pkg::REG_OUTPUT_UPPER:   prdata = {15'd0, output_upper_reg};
            pvl_pkg::REG_OUTPUT_LOWER:   prdata = {15'd0, output_lower_reg};
            pvl_pkg::REG_PERIOD_COUNT:   prdata = {16'd0, period_count_reg};
            default:                     prdata = 32'd0;
        endcase
    end

    assign cfg.setpoint_level = setpoint_level_reg;
    assign cfg.feedback_gain  = feedback_gain_reg;
    assign cfg.prop_gain      = prop_gain_reg;
    assign cfg.int_gain       = int_gain_reg;
    assign cfg.int_step       = int_step_reg;
    assign cfg.output_upper   = output_upper_reg;
    assign cfg.output_lower   = output_lower_reg;
    assign cfg.period_count   = period_count_reg;

endmodule

`default_nettype wire

/* src/pvl_ctrl.sv */
// sequencer for the shared-multiplier pi datapath and the stream handshakes
`default_nettype none

module pvl_ctrl (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    output pvl_pkg::dp_cmd_t cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_FB   = 4'd1;
    localparam logic [3:0] S_ILO  = 4'd2;
    localparam logic [3:0] S_IHI  = 4'd3;
    localparam logic [3:0] S_P    = 4'd4;
    localparam logic [3:0] S_STEP = 4'd5;
    localparam logic [3:0] S_UPD  = 4'd6;
    localparam logic [3:0] S_DUTY = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       load_out;

    // result slot is free when empty or being drained this cycle
    assign load_out = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = pvl_pkg::OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = pvl_pkg::OP_LOAD;
                    state_next = S_FB;
                end
            end
            S_FB:
            begin
                cmd.op     = pvl_pkg::OP_FB;
                state_next = S_ILO;
            end
            S_ILO:
            begin
                cmd.op     = pvl_pkg::OP_ILO;
                state_next = S_IHI;
            end
            S_IHI:
            begin
                cmd.op     = pvl_pkg::OP_IHI;
                state_next = S_P;
            end
            S_P:
            begin
                cmd.op     = pvl_pkg::OP_P;
                state_next = S_STEP;
            end
            S_STEP:
            begin
                cmd.op     = pvl_pkg::OP_STEP;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.op     = pvl_pkg::OP_UPD;
                state_next = S_DUTY;
            end
            S_DUTY:
            begin
                cmd.op     = pvl_pkg::OP_DUTY;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (load_out)
                begin
                    cmd.op     = pvl_pkg::OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* src/pvl_dp.sv */
// pi datapath: one shared multiplier, accumulator, clamp, integrator and result register
`default_nettype none

module pvl_dp (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire pvl_pkg::cfg_t    cfg,
    input  wire pvl_pkg::dp_cmd_t cmd,
    input  wire logic [11:0]      feedback_sample,
    output logic [15:0]           duty_count,
    output logic                  clamped_high,
    output logic                  clamped_low,
    output logic                  integrator_held
);

    logic [11:0]         sample_reg;
    logic signed [41:0]  prod_reg;
    logic signed [17:0]  err_reg;
    logic signed [42:0]  acc_reg;
    logic signed [47:0]  integ_reg;
    logic [16:0]         clamped_reg;
    logic                hi_reg;
    logic                lo_reg;
    logic                held_reg;
    logic [15:0]         duty_count_reg;
    logic                clamped_high_reg;
    logic                clamped_low_reg;
    logic                integrator_held_reg;

    logic signed [24:0]  mul_a;
    logic signed [16:0]  mul_b;
    logic signed [41:0]  mul_p;

    logic signed [42:0]  upper_s;
    logic signed [42:0]  lower_s;
    logic                above;
    logic                below;
    logic                integrate;
    logic signed [48:0]  sum;
    logic signed [47:0]  sum_sat;
    logic [15:0]         duty_sat;

    // operand selection for the shared 25x17 multiplier
    always_comb
    begin
        mul_a = 25'sd0;
        mul_b = 17'sd0;
        unique case (cmd.op)
            pvl_pkg::OP_FB:
            begin
                mul_a = {13'd0, sample_reg};
                mul_b = {1'b0, cfg.feedback_gain};
            end
            pvl_pkg::OP_ILO:
            begin
                mul_a = {1'b0, integ_reg[23:0]};
                mul_b = {1'b0, cfg.int_gain};
            end
            pvl_pkg::OP_IHI:
            begin
                mul_a = {integ_reg[47], integ_reg[47:24]};
                mul_b = {1'b0, cfg.int_gain};
            end
            pvl_pkg::OP_P:
            begin
                mul_a = {{7{err_reg[17]}}, err_reg};
                mul_b = {1'b0, cfg.prop_gain};
            end
            pvl_pkg::OP_STEP:
            begin
                mul_a = {{7{err_reg[17]}}, err_reg};
                mul_b = {1'b0, cfg.int_step};
            end
            pvl_pkg::OP_DUTY:
            begin
                mul_a = {8'd0, clamped_reg};
                mul_b = {1'b0, cfg.period_count};
            end
            default:
            begin
                mul_a = 25'sd0;
                mul_b = 17'sd0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // clamp and conditional integration, evaluated in the update step
    assign upper_s   = {26'd0, cfg.output_upper};
    assign lower_s   = {26'd0, cfg.output_lower};
    assign above     = acc_reg > upper_s;
    assign below     = acc_reg < lower_s;
    assign integrate = ((err_reg > 18'sd0) && (acc_reg < upper_s)) ||
                       ((err_reg < 18'sd0) && (acc_reg > lower_s));
    assign sum       = {integ_reg[47], integ_reg} + {{7{prod_reg[41]}}, prod_reg};

    always_comb
    begin
        unique case (sum[48:47])
            2'b01:   sum_sat = pvl_pkg::INTEG_MAX;
            2'b10:   sum_sat = pvl_pkg::INTEG_MIN;
            default: sum_sat = sum[47:0];
        endcase
    end

    // duty product is at most 17 bits after the shift
    assign duty_sat = prod_reg[32] ? 16'hFFFF : prod_reg[31:16];

    always_ff @(posedge clk)
    begin
        // product holds while the finished tick waits for the result register
        if (cmd.op != pvl_pkg::OP_NONE)
        begin
            prod_reg <= mul_p;
        end
        unique case (cmd.op)
            pvl_pkg::OP_LOAD:
            begin
                sample_reg <= feedback_sample & pvl_pkg::SAMPLE_MASK;
            end
            pvl_pkg::OP_ILO:
            begin
                err_reg <= $signed({1'b0, cfg.setpoint_level}) -
                           $signed({2'b00, prod_reg[27:12]});
            end
            pvl_pkg::OP_IHI:
            begin
                acc_reg <= {27'd0, prod_reg[39:24]};
            end
            pvl_pkg::OP_P:
            begin
                acc_reg <= acc_reg + {prod_reg[41], prod_reg};
            end
            pvl_pkg::OP_STEP:
            begin
                acc_reg <= acc_reg + {{9{prod_reg[41]}}, prod_reg[41:8]};
            end
            pvl_pkg::OP_UPD:
            begin
                hi_reg   <= above;
                lo_reg   <= !above && below;
                held_reg <= !integrate;
                if (above)
                begin
                    clamped_reg <= cfg.output_upper;
                end
                else if (below)
                begin
                    clamped_reg <= cfg.output_lower;
                end
                else
                begin
                    clamped_reg <= acc_reg[16:0];
                end
            end
            pvl_pkg::OP_OUT:
            begin
                duty_count_reg      <= duty_sat;
                clamped_high_reg    <= hi_reg;
                clamped_low_reg     <= lo_reg;
                integrator_held_reg <= held_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg <= 48'sd0;
        end
        else if ((cmd.op == pvl_pkg::OP_UPD) && integrate)
        begin
            integ_reg <= sum_sat;
        end
    end

    assign duty_count      = duty_count_reg;
    assign clamped_high    = clamped_high_reg;
    assign clamped_low     = clamped_low_reg;
    assign integrator_held = integrator_held_reg;

endmodule

`default_nettype wire
